/* hw/rtl/signed_int_to_decimal_ascii_core_defines.svh */
// Assertion macros for the signed integer to decimal ASCII core.
// Used by the top level; needs a clock and an active-low reset in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Implication in the same cycle.
`define S2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define S2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/s2d_pkg.sv */
// Shared types, constants and functions of the signed integer to ASCII core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s2d_pkg;

    localparam int VALUE_W        = 32;
    localparam int DIGIT_COUNT    = 10;
    localparam int DIGIT_W        = 4;
    localparam int BCD_W          = DIGIT_COUNT * DIGIT_W;
    localparam int BITS_PER_STAGE = 4;
    localparam int DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;
    localparam int IDX_W          = $clog2(DIGIT_COUNT);
    localparam int CHAR_W         = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] ASCII_NL    = 7'd10;

    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } conv_t;

    typedef enum logic [1:0] {
        SER_IDLE,
        SER_SIGN,
        SER_DIGIT,
        SER_EOL
    } ser_state_t;

    // Four shift-and-add-3 steps of the double dabble conversion.
    function automatic conv_t dabble_step(input conv_t c);
        conv_t              r;
        logic [BCD_W-1:0]   b;
        logic [VALUE_W-1:0] m;
        r = c;
        b = c.bcd;
        m = c.bin;
        for (int s = 0; s < BITS_PER_STAGE; s++)
        begin
            for (int d = 0; d < DIGIT_COUNT; d++)
            begin
                if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            {b, m} = {b[BCD_W-2:0], m, 1'b0};
        end
        r.bcd = b;
        r.bin = m;
        return r;
    endfunction

    function automatic logic bcd_ok(input logic [BCD_W-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (b[d*DIGIT_W +: DIGIT_W] > 4'd9)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/s2d_channels.sv */
// Valid/ready channel interfaces: integer beats in, character beats out.
// Depends on s2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface s2d_value_if;
    import s2d_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface s2d_char_if;
    import s2d_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

/* hw/rtl/signed_int_to_decimal_ascii_core.sv */
// Top level: signed 32-bit integer in, decimal ASCII characters out.
// Depends on s2d_pkg, s2d_channels, s2d_dabble_stage, s2d_serializer and the defines header.
//
//  channel    dir  payload                      beat
//  value_ch   in   value[31:0] signed           one integer
//  char_ch    out  char_code[6:0], last_char    one character, last on newline
//
// The first character passes through the input register, eight conversion stages,
// the digit load in the character unit and the character register.
// Each integer yields 2 to 12 characters;
// the next integer is taken while the newline goes out.
// Reset clears all valid bits and the character unit's state.
// A stall on char_ch backs up through every stage without dropping or repeating beats.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_ascii_core_defines.svh"

module signed_int_to_decimal_ascii_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    s2d_value_if.sink  value_ch,
    s2d_char_if.source char_ch
);
    import s2d_pkg::*;

    logic               in_valid_reg;
    conv_t              in_data_reg;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;

    logic               link_valid [DABBLE_STAGES+1];
    logic               link_ready [DABBLE_STAGES+1];
    conv_t              link_data  [DABBLE_STAGES+1];

    assign raw = value_ch.value;
    assign mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

    assign value_ch.ready = !in_valid_reg || link_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (value_ch.ready)
        begin
            in_valid_reg <= value_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_ch.valid && value_ch.ready)
        begin
            in_data_reg.neg <= raw[VALUE_W-1];
            in_data_reg.bcd <= '0;
            in_data_reg.bin <= mag;
        end
    end

    assign link_valid[0] = in_valid_reg;
    assign link_data[0]  = in_data_reg;

    for (genvar g = 0; g < DABBLE_STAGES; g++)
    begin : g_dabble
        s2d_dabble_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .feed_valid (link_valid[g]),
            .feed_ready (link_ready[g]),
            .feed_data  (link_data[g]),
            .emit_valid (link_valid[g+1]),
            .emit_ready (link_ready[g+1]),
            .emit_data  (link_data[g+1])
        );
    end

    s2d_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed_valid (link_valid[DABBLE_STAGES]),
        .feed_ready (link_ready[DABBLE_STAGES]),
        .feed_data  (link_data[DABBLE_STAGES]),
        .char_ch    (char_ch)
    );

    `S2D_ASSERT_NOW(a_bcd_digits, clk, rst_n, link_valid[DABBLE_STAGES], bcd_ok(link_data[DABBLE_STAGES].bcd), "conversion produced a digit above nine")
    `S2D_ASSERT_NOW(a_last_is_nl, clk, rst_n, char_ch.valid, (char_ch.char_code == ASCII_NL) == char_ch.last_char, "newline and last flag disagree")
    `S2D_ASSERT_NEXT(a_stall_holds_stage, clk, rst_n, link_valid[DABBLE_STAGES] && !link_ready[DABBLE_STAGES], link_valid[DABBLE_STAGES], "conversion result dropped under stall")

endmodule

`default_nettype wire

/* hw/rtl/s2d_dabble_stage.sv */
// One registered stage of the binary to BCD pipeline: four double dabble steps.
// Depends on s2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s2d_dabble_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           feed_valid,
    output logic                feed_ready,
    input  wire s2d_pkg::conv_t feed_data,
    output logic                emit_valid,
    input  wire logic           emit_ready,
    output s2d_pkg::conv_t      emit_data
);
    import s2d_pkg::*;

    logic  valid_reg;
    conv_t data_reg;

    assign feed_ready = !valid_reg || emit_ready;
    assign emit_valid = valid_reg;
    assign emit_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (feed_ready)
        begin
            valid_reg <= feed_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feed_valid && feed_ready)
        begin
            data_reg <= dabble_step(feed_data);
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/s2d_serializer.sv */
// Turns one BCD result into a run of ASCII characters, one beat per cycle while char_ch is ready.
// Depends on s2d_pkg and s2d_channels.
`timescale 1ns / 1ps
`default_nettype none

module s2d_serializer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           feed_valid,
    output logic                feed_ready,
    input  wire s2d_pkg::conv_t feed_data,
    s2d_char_if.source          char_ch
);
    import s2d_pkg::*;

    ser_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BCD_W-1:0]  digits_reg, digits_next;
    logic              ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  lead;
    logic [DIGIT_W-1:0] cur_digit;
    logic              advance;

    assign char_ch.valid     = ovalid_reg;
    assign char_ch.char_code = char_reg;
    assign char_ch.last_char = last_reg;

    assign cur_digit = digits_reg[{idx_reg, 2'b00} +: DIGIT_W];
    assign advance   = !ovalid_reg || char_ch.ready;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        digits_next = digits_reg;
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        feed_ready  = 1'b0;
        lead        = '0;

        // most significant nonzero digit; zero keeps digit 0
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (feed_data.bcd[d*DIGIT_W +: DIGIT_W] != '0)
            begin
                lead = IDX_W'(d);
            end
        end

        if (char_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            SER_IDLE:
            begin
                feed_ready = 1'b1;
            end
            SER_SIGN:
            begin
                if (advance)
                begin
                    char_next   = ASCII_MINUS;
                    last_next   = 1'b0;
                    ovalid_next = 1'b1;
                    state_next  = SER_DIGIT;
                end
            end
            SER_DIGIT:
            begin
                if (advance)
                begin
                    char_next   = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
                    last_next   = 1'b0;
                    ovalid_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = SER_EOL;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            SER_EOL:
            begin
                if (advance)
                begin
                    char_next   = ASCII_NL;
                    last_next   = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = SER_IDLE;
                    feed_ready  = 1'b1;
                end
            end
            default:
            begin
                state_next = SER_IDLE;
            end
        endcase

        if (feed_valid && feed_ready)
        begin
            digits_next = feed_data.bcd;
            idx_next    = lead;
            state_next  = feed_data.neg ? SER_SIGN : SER_DIGIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SER_IDLE;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire
